// ----- src/swmd_pkg.sv -----
// Shared constants and types for the stack with middle delete.
`timescale 1ns / 1ps
`default_nettype none
package swmd_pkg;

    localparam int unsigned DW        = 32;
    localparam int unsigned DEPTH_DEF = 64;

    localparam logic [1:0] FN_PUSH   = 2'd0;
    localparam logic [1:0] FN_POP    = 2'd1;
    localparam logic [1:0] FN_DELMID = 2'd2;
    localparam logic [1:0] FN_NONE   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // per-cell data move
    typedef enum logic [1:0] {
        DOP_HOLD = 2'd0,
        DOP_PUSH = 2'd1,
        DOP_POP  = 2'd2,
        DOP_DEL  = 2'd3
    } data_op_t;

    // middle thermometer move (bit set for cells at or below the middle)
    typedef enum logic [2:0] {
        TOP_HOLD = 3'd0,
        TOP_SET  = 3'd1,
        TOP_CLR  = 3'd2,
        TOP_INC  = 3'd3,
        TOP_DEC  = 3'd4
    } thermo_op_t;

    typedef struct packed {
        data_op_t   dop;
        thermo_op_t top;
    } swmd_ctrl_t;

endpackage
`default_nettype wire

// ----- src/swmd_cell.sv -----
// One stack cell: a data word and its middle-thermometer bit.
`timescale 1ns / 1ps
`default_nettype none
module swmd_cell
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire swmd_pkg::swmd_ctrl_t     ctrl,
    input  wire logic [swmd_pkg::DW-1:0]  prev_data,
    input  wire logic [swmd_pkg::DW-1:0]  next_data,
    input  wire logic                     prev_b,
    input  wire logic                     next_b,
    output logic      [swmd_pkg::DW-1:0]  data,
    output logic                          b,
    output logic      [swmd_pkg::DW-1:0]  sel
);
    import swmd_pkg::*;

    logic [DW-1:0] data_reg;
    logic [DW-1:0] data_next;
    logic          b_reg;
    logic          b_next;

    always_comb
    begin
        case (ctrl.dop)
            DOP_HOLD: data_next = data_reg;
            DOP_PUSH: data_next = prev_data;
            DOP_POP:  data_next = next_data;
            DOP_DEL:  data_next = b_reg ? next_data : data_reg;
            default:  data_next = data_reg;
        endcase
    end

    always_comb
    begin
        case (ctrl.top)
            TOP_HOLD: b_next = b_reg;
            TOP_SET:  b_next = 1'b1;
            TOP_CLR:  b_next = 1'b0;
            TOP_INC:  b_next = prev_b;
            TOP_DEC:  b_next = next_b;
            default:  b_next = b_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg <= 1'b0;
        end
        else
        begin
            b_reg <= b_next;
        end
    end

    assign data = data_reg;
    assign b    = b_reg;
    // middle cell is the first one with the thermometer bit set
    assign sel  = data_reg & {DW{b_reg & ~prev_b}};

endmodule
`default_nettype wire

// ----- src/stack_with_middle_delete.sv -----
// Top level: bounded stack with middle read and middle delete over a row of cells.
//
//  channel  | handshake                 | fields
//  ---------+---------------------------+-----------------------------------------------
//  item     | item_valid / item_stall   | func, push_value
//  result   | result_valid / result_stall | removed_value, status, middle_value,
//           |                           | middle_valid, depth_used
//
// One item per cycle unless item_stall; items pass stage 1, then the result register.
// Cell 0 is the top; push and pop shift all cells, delete only the middle and below.
// The middle word is picked by an AND-OR over the cells' one-hot middle marks.
// Reset clears the count and the marks; cell data is not reset.
// While a result is stalled one more item is taken into stage 1, then item_stall rises.
`timescale 1ns / 1ps
`default_nettype none
module stack_with_middle_delete
#(
    parameter  int unsigned DEPTH = swmd_pkg::DEPTH_DEF,
    localparam int unsigned CW    = $clog2(DEPTH + 1)
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            item_valid,
    output logic                                 item_stall,
    input  wire logic [1:0]                      func,
    input  wire logic signed [swmd_pkg::DW-1:0]  push_value,
    output logic                                 result_valid,
    input  wire logic                            result_stall,
    output logic signed [swmd_pkg::DW-1:0]       removed_value,
    output logic [1:0]                           status,
    output logic signed [swmd_pkg::DW-1:0]       middle_value,
    output logic                                 middle_valid,
    output logic [CW-1:0]                        depth_used
);
    import swmd_pkg::*;

    logic [DW-1:0] cell_data [DEPTH];
    logic [DW-1:0] cell_sel  [DEPTH];
    logic          cell_b    [DEPTH];
    logic [DW-1:0] mid_sel;

    swmd_ctrl_t    ctrl;
    logic          accept;
    logic          advance;
    logic          empty;
    logic          full;
    logic          one_left;

    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          p1_valid_reg;
    logic          p1_valid_next;
    logic [DW-1:0] p1_removed_reg;
    logic [DW-1:0] p1_removed_next;
    logic [1:0]    p1_status_reg;
    logic [1:0]    p1_status_next;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic [DW-1:0] out_removed_reg;
    logic [1:0]    out_status_reg;
    logic [DW-1:0] out_mid_reg;
    logic          out_mid_valid_reg;
    logic [CW-1:0] out_count_reg;

    genvar gi;
    generate
        for (gi = 0; gi < int'(DEPTH); gi++)
        begin : g_cell
            logic [DW-1:0] prev_d;
            logic [DW-1:0] next_d;
            logic          prev_bit;
            logic          next_bit;
            if (gi == 0)
            begin : g_first
                assign prev_d   = push_value;
                assign prev_bit = 1'b0;
            end
            else
            begin : g_mid
                assign prev_d   = cell_data[gi-1];
                assign prev_bit = cell_b[gi-1];
            end
            if (gi == int'(DEPTH) - 1)
            begin : g_last
                assign next_d   = '0;
                assign next_bit = 1'b1;
            end
            else
            begin : g_inner
                assign next_d   = cell_data[gi+1];
                assign next_bit = cell_b[gi+1];
            end
            swmd_cell u_cell
            (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .prev_data (prev_d),
                .next_data (next_d),
                .prev_b    (prev_bit),
                .next_b    (next_bit),
                .data      (cell_data[gi]),
                .b         (cell_b[gi]),
                .sel       (cell_sel[gi])
            );
        end
    endgenerate

    always_comb
    begin
        mid_sel = '0;
        for (int i = 0; i < int'(DEPTH); i++)
        begin
            mid_sel = mid_sel | cell_sel[i];
        end
    end

    assign advance    = p1_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = p1_valid_reg && !advance;
    assign accept     = item_valid && !item_stall;

    assign empty    = (count_reg == '0);
    assign full     = (count_reg == CW'(DEPTH));
    assign one_left = (count_reg == CW'(1));

    always_comb
    begin
        ctrl.dop        = DOP_HOLD;
        ctrl.top        = TOP_HOLD;
        count_next      = count_reg;
        p1_removed_next = '0;
        p1_status_next  = ST_OK;
        case (func)
            FN_PUSH:
            begin
                if (full)
                begin
                    p1_status_next = ST_FULL;
                end
                else
                begin
                    ctrl.dop   = DOP_PUSH;
                    count_next = count_reg + CW'(1);
                    if (empty)
                    begin
                        ctrl.top = TOP_SET;
                    end
                    else if (!count_reg[0])
                    begin
                        ctrl.top = TOP_INC;
                    end
                end
            end
            FN_POP, FN_DELMID:
            begin
                if (empty)
                begin
                    p1_status_next = ST_EMPTY;
                end
                else
                begin
                    if (func == FN_POP)
                    begin
                        ctrl.dop        = DOP_POP;
                        p1_removed_next = cell_data[0];
                    end
                    else
                    begin
                        ctrl.dop        = DOP_DEL;
                        p1_removed_next = mid_sel;
                    end
                    count_next = count_reg - CW'(1);
                    if (one_left)
                    begin
                        ctrl.top = TOP_CLR;
                    end
                    else if (count_reg[0])
                    begin
                        ctrl.top = TOP_DEC;
                    end
                end
            end
            FN_NONE:
            begin
                p1_status_next = ST_OK;
            end
            default:
            begin
                p1_status_next = ST_OK;
            end
        endcase
        if (!accept)
        begin
            ctrl.dop   = DOP_HOLD;
            ctrl.top   = TOP_HOLD;
            count_next = count_reg;
        end
    end

    always_comb
    begin
        if (accept)
        begin
            p1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            p1_valid_next = 1'b0;
        end
        else
        begin
            p1_valid_next = p1_valid_reg;
        end

        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_stall)
        begin
            out_valid_next = out_valid_reg;
        end
        else
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            p1_valid_reg  <= p1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // stage 2 sees the state left by the item in stage 1
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p1_removed_reg <= p1_removed_next;
            p1_status_reg  <= p1_status_next;
        end
        if (advance)
        begin
            out_removed_reg   <= p1_removed_reg;
            out_status_reg    <= p1_status_reg;
            out_mid_reg       <= mid_sel;
            out_mid_valid_reg <= !empty;
            out_count_reg     <= count_reg;
        end
    end

    assign result_valid  = out_valid_reg;
    assign removed_value = out_removed_reg;
    assign status        = out_status_reg;
    assign middle_value  = out_mid_reg;
    assign middle_valid  = out_mid_valid_reg;
    assign depth_used    = out_count_reg;

endmodule
`default_nettype wire
